// ----- hw/rtl/tdcs_pkg.sv -----
// Shared types, codes and constants for the tree depth chunk splitter.
package tdcs_pkg;

   // Depth field width and derived divider width
   localparam int DEPTH_W = 8;
   localparam int DIV_W = DEPTH_W + 1;

   // Default for the chunk count limit
   localparam int MAX_CHUNKS_DEF = 64;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_MINIMUM = 2'd2;

   // Configuration reset values
   localparam logic [DEPTH_W-1:0] CHUNK_MAX_RST = 8'd8;
   localparam logic [DEPTH_W-1:0] CHUNK_MIN_RST = 8'd1;

   // Error codes on the result channel
   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_MAX_ZERO      = 3'd1,
      ERR_MIN_ZERO      = 3'd2,
      ERR_MIN_ABOVE_MAX = 3'd3,
      ERR_TOO_MANY      = 3'd4
   } err_type;

   // Divider operand selection
   typedef enum logic [1:0] {
      DIV_COUNT,
      DIV_SPLIT,
      DIV_REST
   } div_sel_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_COUNT,
      S_SPLIT_GO,
      S_SPLIT,
      S_REST_GO,
      S_REST,
      S_EMIT
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_count;
      logic        load_split;
      logic        load_rest;
      logic        emit;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic single;
      logic div_done;
      logic too_many;
      logic use_min;
      logic out_free;
      logic last;
   } dp_status_type;

endpackage

// ----- hw/rtl/tdcs_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module tdcs_div import tdcs_pkg::*; #(
   parameter int W = DIV_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CW = (W > 1) ? $clog2(W) : 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // One restoring step: shift in the next dividend bit, try subtract
   always_comb begin
      shifted = {rem_ff, dvd_ff[W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W - 1);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (diff[W]) begin
            rem_in = shifted[W-1:0];
            dvd_in = {dvd_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            dvd_in = {dvd_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial result registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/tdcs_datapath.sv -----
// Datapath: configuration, item registers, divider, chunk value and result register.
module tdcs_datapath import tdcs_pkg::*; #(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DEPTH_W-1:0]   csr_wdata,
   input  logic [DEPTH_W-1:0]   req_tree_depth,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DEPTH_W-1:0]   rsp_chunk_depth,
   output logic                 rsp_last_chunk,
   output logic [2:0]           rsp_error
);

   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

   logic [DEPTH_W-1:0] chunk_max_ff;
   logic [DEPTH_W-1:0] chunk_min_ff;
   logic               use_min_ff;

   logic [DEPTH_W-1:0] depth_ff;
   err_type            err_ff;
   logic               single_ff;
   logic [CNT_W-1:0]   num_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [DEPTH_W-1:0] q_ff;
   logic [CNT_W-1:0]   r_ff;
   logic [DEPTH_W-1:0] c0_ff;

   logic               rsp_valid_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;
   logic               rsp_last_ff;
   err_type            rsp_err_ff;

   err_type            in_err;
   logic [DIV_W-1:0]   div_dvd;
   logic [DIV_W-1:0]   div_dsr;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;
   logic [DIV_W-1:0]   div_rem;
   logic [DEPTH_W-1:0] ceil_q;
   logic [DEPTH_W-1:0] c0_val;
   logic [DEPTH_W-1:0] chunk_val;
   logic               last_val;
   logic               out_free;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_max_ff <= CHUNK_MAX_RST;
         chunk_min_ff <= CHUNK_MIN_RST;
         use_min_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHUNK_MAX:   chunk_max_ff <= csr_wdata;
            CSR_CHUNK_MIN:   chunk_min_ff <= csr_wdata;
            CSR_USE_MINIMUM: use_min_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Settings check, in priority order
   always_comb begin
      priority if (chunk_max_ff == '0) begin
         in_err = ERR_MAX_ZERO;
      end else if (use_min_ff && chunk_min_ff == '0) begin
         in_err = ERR_MIN_ZERO;
      end else if (use_min_ff && chunk_min_ff > chunk_max_ff) begin
         in_err = ERR_MIN_ABOVE_MAX;
      end else begin
         in_err = ERR_NONE;
      end
   end

   // Divider operands: chunk count, even split, split of the rest after chunk zero
   always_comb begin
      unique case (cmd.div_sel)
         DIV_COUNT: begin
            div_dvd = {1'b0, depth_ff} + {1'b0, chunk_max_ff} - DIV_W'(1);
            div_dsr = {1'b0, chunk_max_ff};
         end
         DIV_SPLIT: begin
            div_dvd = {1'b0, depth_ff};
            div_dsr = DIV_W'(num_ff);
         end
         DIV_REST: begin
            div_dvd = {1'b0, depth_ff - c0_ff};
            div_dsr = DIV_W'(num_ff - CNT_W'(1));
         end
         default: begin
            div_dvd = '0;
            div_dsr = '0;
         end
      endcase
   end

   tdcs_div #(
      .W(DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // First chunk in minimum mode: ceiling, clamped to the configured range
   always_comb begin
      ceil_q = div_quot[DEPTH_W-1:0] + DEPTH_W'(div_rem != '0);
      c0_val = ceil_q;
      if (c0_val < chunk_min_ff) begin
         c0_val = chunk_min_ff;
      end
      if (c0_val > chunk_max_ff) begin
         c0_val = chunk_max_ff;
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         depth_ff  <= req_tree_depth;
         err_ff    <= in_err;
         single_ff <= (in_err != ERR_NONE) || (req_tree_depth <= chunk_max_ff);
      end
      if (cmd.load_count) begin
         num_ff <= CNT_W'(div_quot);
         if (div_quot > DIV_W'(MAX_CHUNKS)) begin
            err_ff    <= ERR_TOO_MANY;
            single_ff <= 1'b1;
         end
      end
      if (cmd.load_split) begin
         q_ff   <= div_quot[DEPTH_W-1:0];
         r_ff   <= CNT_W'(div_rem);
         c0_ff  <= c0_val;
         idx_ff <= '0;
      end
      if (cmd.load_rest) begin
         q_ff <= div_quot[DEPTH_W-1:0];
         r_ff <= CNT_W'(div_rem);
      end
      if (cmd.emit) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // Current chunk value and last flag
   always_comb begin
      priority if (err_ff != ERR_NONE) begin
         chunk_val = '0;
      end else if (single_ff) begin
         chunk_val = depth_ff;
      end else if (use_min_ff) begin
         if (idx_ff == '0) begin
            chunk_val = c0_ff;
         end else begin
            chunk_val = q_ff + DEPTH_W'(idx_ff <= r_ff);
         end
      end else begin
         chunk_val = q_ff + DEPTH_W'(idx_ff < r_ff);
      end
      last_val = single_ff || (idx_ff == num_ff - CNT_W'(1));
   end

   // Result register: load on emit, drop after transfer
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_depth_ff <= chunk_val;
         rsp_last_ff  <= last_val;
         rsp_err_ff   <= err_ff;
      end
   end

   assign status.single   = single_ff;
   assign status.div_done = div_done;
   assign status.too_many = div_quot > DIV_W'(MAX_CHUNKS);
   assign status.use_min  = use_min_ff;
   assign status.out_free = out_free;
   assign status.last     = last_val;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chunk_depth = rsp_depth_ff;
   assign rsp_last_chunk  = rsp_last_ff;
   assign rsp_error       = rsp_err_ff;

endmodule

// ----- hw/rtl/tdcs_ctrl.sv -----
// Controller state machine: sequences the divisions and the chunk transfers.
module tdcs_ctrl import tdcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_COUNT;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            if (status.single) begin
               state_in = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_COUNT;
               state_in      = S_COUNT;
            end
         end
         S_COUNT: begin
            if (status.div_done) begin
               cmd.load_count = 1'b1;
               state_in = status.too_many ? S_EMIT : S_SPLIT_GO;
            end
         end
         S_SPLIT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SPLIT;
            state_in      = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.div_sel = DIV_SPLIT;
            if (status.div_done) begin
               cmd.load_split = 1'b1;
               state_in = status.use_min ? S_REST_GO : S_EMIT;
            end
         end
         S_REST_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_REST;
            state_in      = S_REST;
         end
         S_REST: begin
            cmd.div_sel = DIV_REST;
            if (status.div_done) begin
               cmd.load_rest = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tree_depth_chunk_splitter_unit.sv -----
// Top level of the tree depth chunk splitter.
//
// Request channel (req_valid, req_stall, req_tree_depth) takes one tree depth
// per transfer. Result channel (rsp_valid, rsp_stall, rsp_chunk_depth,
// rsp_last_chunk, rsp_error) returns one transfer per chunk, rsp_last_chunk
// set on the final one; a bad setting or an overlong run gives a single
// transfer with the error code and a zero depth.
// The csr_ port writes the chunk maximum (index 0), the chunk minimum (1) and
// use_minimum (2); the user must write them only while the block is idle, and
// the block itself does not enforce it. Registers reset to 8, 1 and 0.
// A depth that fits in one chunk, or a settings error, needs no division; an
// overlong run is found by the first one. Otherwise the one shared bit-serial
// divider runs twice in plain mode and three times in minimum mode, and the
// chunks then follow one per cycle while the result channel does not stall.
// One item is worked at a time; the next request is taken in the cycle after
// the last chunk is loaded in the result register, while it still waits.
// A stall on the result channel holds the result register and pauses chunk
// output. Reset is synchronous and returns the block to idle with no result.
module tree_depth_chunk_splitter_unit import tdcs_pkg::*; #(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DEPTH_W-1:0]   req_tree_depth,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DEPTH_W-1:0]   rsp_chunk_depth,
   output logic                 rsp_last_chunk,
   output logic [2:0]           rsp_error,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DEPTH_W-1:0]   csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tdcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tdcs_datapath #(
      .MAX_CHUNKS(MAX_CHUNKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tree_depth  (req_tree_depth),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chunk_depth (rsp_chunk_depth),
      .rsp_last_chunk  (rsp_last_chunk),
      .rsp_error       (rsp_error)
   );

endmodule

// ----- hw/rtl/tdcs_checker.sv -----
// Port-level checker for the tree depth chunk splitter, bound to the top level.
module tdcs_checker import tdcs_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [DEPTH_W-1:0]   rsp_chunk_depth,
   input logic                 rsp_last_chunk,
   input logic [2:0]           rsp_error
);

   // An error result is a lone, final transfer with zero depth
   a_err_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |-> rsp_last_chunk && rsp_chunk_depth == '0)
      else $error("error result not final or nonzero depth");

   // Codes stay within the defined set
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error <= ERR_TOO_MANY)
      else $error("undefined error code");

   // A chunk that is not the last one carries depth and no error
   a_mid_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_chunk |-> rsp_chunk_depth != '0 && rsp_error == ERR_NONE)
      else $error("empty or failed chunk inside a run");

   // One item at a time: the request side stalls right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chunk_depth)
         && $stable(rsp_last_chunk) && $stable(rsp_error))
      else $error("stalled result changed");

endmodule

bind tree_depth_chunk_splitter_unit tdcs_checker u_tdcs_checker (.*);

// ----- test/tree_depth_chunk_splitter_unit_tb.sv -----
// Self-checking testbench for the tree depth chunk splitter top level.
module tree_depth_chunk_splitter_unit_tb;
   import tdcs_pkg::*;

   localparam int CLK_HALF = 6;
   localparam int CHUNK_LIMIT = MAX_CHUNKS_DEF;
   localparam int TIMEOUT_CYCLES = 3_000_000;
   localparam int SETTLE_CYCLES = 2 + 3 * (DIV_W + 2) + CHUNK_LIMIT + 20;
   localparam int ITEMS_PER_SETTING = 24;
   localparam int SETTINGS_PER_MODE = 4;
   // Index with no register behind it; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [DEPTH_W-1:0] depth;
      logic               last;
      err_type            err;
   } chunk_type;

   typedef struct {
      logic                 is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [DEPTH_W-1:0]   value;
      logic                 known;
      logic [DEPTH_W-1:0]   e_depth;
      err_type              e_err;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DEPTH_W-1:0]   req_tree_depth = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DEPTH_W-1:0]   rsp_chunk_depth;
   logic                 rsp_last_chunk;
   logic [2:0]           rsp_error;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DEPTH_W-1:0]   csr_wdata = '0;

   // Local copy of the configuration
   logic [DEPTH_W-1:0]   cfg_max = CHUNK_MAX_RST;
   logic [DEPTH_W-1:0]   cfg_min = CHUNK_MIN_RST;
   logic                 cfg_use_min = 1'b0;

   chunk_type pending_chunks[$];
   step_type  directed_steps[$];
   int        fail_count = 0;
   int        gap_pct = 0;
   int        stall_pct = 0;

   tree_depth_chunk_splitter_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tree_depth  (req_tree_depth),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chunk_depth (rsp_chunk_depth),
      .rsp_last_chunk  (rsp_last_chunk),
      .rsp_error       (rsp_error),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("tree_depth_chunk_splitter_unit_tb NOT OK");
      $finish;
   end

   function automatic chunk_type make_chunk(logic [DEPTH_W-1:0] depth, logic last,
                                            err_type err);
      chunk_type c;
      c.depth = depth;
      c.last = last;
      c.err = err;
      return c;
   endfunction

   // Append one expected chunk at the tail of the queue
   function automatic void queue_chunk(chunk_type c);
      pending_chunks.insert(pending_chunks.size(), c);
   endfunction

   // Append one row at the tail of the directed table
   function automatic void add_step(step_type s);
      directed_steps.insert(directed_steps.size(), s);
   endfunction

   // Compute the chunk run for one tree depth and queue it
   function automatic void split_depth(logic [DEPTH_W-1:0] depth);
      int num;
      int rem;
      int left;
      int c;
      if (cfg_max == 0) begin
         queue_chunk(make_chunk('0, 1'b1, ERR_MAX_ZERO));
         return;
      end
      if (cfg_use_min && cfg_min == 0) begin
         queue_chunk(make_chunk('0, 1'b1, ERR_MIN_ZERO));
         return;
      end
      if (cfg_use_min && cfg_min > cfg_max) begin
         queue_chunk(make_chunk('0, 1'b1, ERR_MIN_ABOVE_MAX));
         return;
      end
      if (depth <= cfg_max) begin
         queue_chunk(make_chunk(depth, 1'b1, ERR_NONE));
         return;
      end
      num = (int'(depth) + int'(cfg_max) - 1) / int'(cfg_max);
      if (num > CHUNK_LIMIT) begin
         queue_chunk(make_chunk('0, 1'b1, ERR_TOO_MANY));
         return;
      end
      rem = int'(depth);
      for (int i = 0; i < num; i++) begin
         left = num - i;
         if (cfg_use_min) begin
            c = (rem + left - 1) / left;
            if (i == 0 && c < int'(cfg_min)) c = int'(cfg_min);
            if (c > int'(cfg_max)) c = int'(cfg_max);
         end else begin
            c = int'(depth) / num + ((i < int'(depth) % num) ? 1 : 0);
         end
         c = c & ((1 << DEPTH_W) - 1);
         rem = (rem - c) & ((1 << DEPTH_W) - 1);
         queue_chunk(make_chunk(c[DEPTH_W-1:0], i + 1 == num, ERR_NONE));
      end
   endfunction

   // Receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Check every result transfer against the oldest expectation
   always @(posedge clock) begin
      chunk_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chunks.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result: depth %0d last %0b error %0d",
                        rsp_chunk_depth, rsp_last_chunk, rsp_error);
            fail_count++;
         end else begin
            e = pending_chunks.pop_front();
            if (rsp_chunk_depth !== e.depth || rsp_last_chunk !== e.last ||
                rsp_error !== e.err) begin
               if (fail_count < 10)
                  $display("mismatch: expected depth %0d last %0b error %0d, got %0d %0b %0d",
                           e.depth, e.last, e.err, rsp_chunk_depth, rsp_last_chunk,
                           rsp_error);
               fail_count++;
            end
         end
      end
   end

   // Register write; called at a falling edge, returns at a falling edge
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DEPTH_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CHUNK_MAX: cfg_max = value;
         CSR_CHUNK_MIN: cfg_min = value;
         CSR_USE_MINIMUM: cfg_use_min = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Present one tree depth and hold it until the transfer
   task automatic send_depth(logic [DEPTH_W-1:0] depth, logic known,
                             logic [DEPTH_W-1:0] e_depth, err_type e_err);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tree_depth <= depth;
      do @(posedge clock); while (req_stall);
      if (known) queue_chunk(make_chunk(e_depth, 1'b1, e_err));
      else split_depth(depth);
      @(negedge clock);
   endtask

   // Drop the request and wait for every expected result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_chunks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic step_type cfg_row(logic [CSR_IDX_W-1:0] idx,
                                        logic [DEPTH_W-1:0] value);
      step_type s;
      s = '{1'b1, idx, value, 1'b0, '0, ERR_NONE};
      return s;
   endfunction

   function automatic step_type item_row(logic [DEPTH_W-1:0] depth);
      step_type s;
      s = '{1'b0, '0, depth, 1'b0, '0, ERR_NONE};
      return s;
   endfunction

   function automatic step_type known_row(logic [DEPTH_W-1:0] depth,
                                          logic [DEPTH_W-1:0] e_depth, err_type e_err);
      step_type s;
      s = '{1'b0, '0, depth, 1'b1, e_depth, e_err};
      return s;
   endfunction

   // Pick a random register setting, mostly legal, and write it
   task automatic random_setting();
      logic [DEPTH_W-1:0] mx;
      logic [DEPTH_W-1:0] mn;
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) mx = '0;
      else if (r < 40) mx = DEPTH_W'($urandom_range(1, 8));
      else if (r < 55) mx = 8'd255;
      else mx = DEPTH_W'($urandom_range(1, 255));
      r = $urandom_range(0, 99);
      if (r < 8) mn = '0;
      else if (r < 16 && mx < 8'd255) mn = DEPTH_W'($urandom_range(int'(mx) + 1, 255));
      else mn = DEPTH_W'($urandom_range(1, (mx == 0) ? 1 : int'(mx)));
      write_reg(CSR_CHUNK_MAX, mx);
      write_reg(CSR_CHUNK_MIN, mn);
      write_reg(CSR_USE_MINIMUM, DEPTH_W'($urandom_range(0, 1)));
   endtask

   // Random depth, mostly within the chunk limit of the current setting
   function automatic logic [DEPTH_W-1:0] random_depth();
      int r;
      int top;
      r = $urandom_range(0, 99);
      top = int'(cfg_max) * CHUNK_LIMIT;
      if (top > 255) top = 255;
      if (r < 10) return DEPTH_W'($urandom_range(0, 255));
      else if (r < 22) return DEPTH_W'($urandom_range(0, int'(cfg_max)));
      else return DEPTH_W'($urandom_range(0, top));
   endfunction

   initial begin
      step_type s;

      // Directed table: reset values, extremes, every error and its priority
      add_step(known_row(8'd0, 8'd0, ERR_NONE));
      add_step(known_row(8'd8, 8'd8, ERR_NONE));
      add_step(item_row(8'd9));
      add_step(item_row(8'd255));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd255));
      add_step(known_row(8'd255, 8'd255, ERR_NONE));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd1));
      add_step(item_row(8'd64));
      add_step(known_row(8'd65, 8'd0, ERR_TOO_MANY));
      add_step(known_row(8'd255, 8'd0, ERR_TOO_MANY));
      add_step(known_row(8'd1, 8'd1, ERR_NONE));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd0));
      add_step(known_row(8'd5, 8'd0, ERR_MAX_ZERO));
      add_step(known_row(8'd0, 8'd0, ERR_MAX_ZERO));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd10));
      add_step(cfg_row(CSR_USE_MINIMUM, 8'd1));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd0));
      add_step(known_row(8'd20, 8'd0, ERR_MIN_ZERO));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd11));
      add_step(known_row(8'd3, 8'd0, ERR_MIN_ABOVE_MAX));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd0));
      add_step(known_row(8'd3, 8'd0, ERR_MAX_ZERO));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd10));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd10));
      add_step(item_row(8'd25));
      add_step(known_row(8'd10, 8'd10, ERR_NONE));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd1));
      add_step(item_row(8'd25));
      add_step(item_row(8'd255));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd4));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd4));
      add_step(item_row(8'd255));
      add_step(known_row(8'd0, 8'd0, ERR_NONE));
      add_step(cfg_row(CSR_CHUNK_MAX, 8'd3));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd3));
      add_step(known_row(8'd200, 8'd0, ERR_TOO_MANY));
      // Plain mode ignores a zero minimum; the unused index changes nothing
      add_step(cfg_row(CSR_USE_MINIMUM, 8'd0));
      add_step(cfg_row(CSR_CHUNK_MIN, 8'd0));
      add_step(cfg_row(CSR_UNUSED, 8'hFF));
      add_step(item_row(8'd17));

      // Hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table with sender-light, receiver-heavy idling
      gap_pct = 14;
      stall_pct = 73;
      foreach (directed_steps[i]) begin
         s = directed_steps[i];
         if (s.is_cfg) begin
            drain_results();
            write_reg(s.idx, s.value);
         end else begin
            send_depth(s.value, s.known, s.e_depth, s.e_err);
         end
      end
      drain_results();

      // Random part: sender-light idling, receiver-light idling, then none
      for (int mode = 0; mode < 3; mode++) begin
         gap_pct = (mode == 0) ? 14 : (mode == 1) ? 73 : 0;
         stall_pct = (mode == 0) ? 73 : (mode == 1) ? 14 : 0;
         for (int k = 0; k < SETTINGS_PER_MODE; k++) begin
            random_setting();
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
               send_depth(random_depth(), 1'b0, '0, ERR_NONE);
            drain_results();
         end
      end

      // Let any stray result show up, then report
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_chunks.size() == 0) begin
         $display("tree_depth_chunk_splitter_unit_tb OK");
      end else begin
         $display("tree_depth_chunk_splitter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
